[rtl/aes128_pkg.sv]
`timescale 1ns / 1ps
package aes128_pkg;

  localparam int BlockW  = 128;
  localparam int HalfW   = 64;
  localparam int NumRnd  = 10;
  localparam int RkIdxW  = 4;
  localparam int CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] CfgKeyUpper = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgKeyLower = 1'b1;

  typedef logic [BlockW-1:0] block_t;
  typedef logic [7:0]        byte_t;

  localparam byte_t SBOX [256] = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
  };

  localparam byte_t RCON [NumRnd] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  function automatic byte_t xtime(input byte_t v);
    xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // SubBytes + ShiftRows; byte 0 sits in bits 127:120
  function automatic block_t sub_shift(input block_t s);
    block_t t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[BlockW-1-8*(4*c+r) -: 8] = SBOX[s[BlockW-1-8*(4*(((c+r)%4))+r) -: 8]];
      end
    end
    sub_shift = t;
  endfunction

  function automatic block_t mix_columns(input block_t s);
    block_t t;
    byte_t  a0, a1, a2, a3;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = s[BlockW-1-32*c -: 8];
      a1 = s[BlockW-9-32*c -: 8];
      a2 = s[BlockW-17-32*c -: 8];
      a3 = s[BlockW-25-32*c -: 8];
      t[BlockW-1-32*c -: 8]  = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      t[BlockW-9-32*c -: 8]  = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      t[BlockW-17-32*c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      t[BlockW-25-32*c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    mix_columns = t;
  endfunction

  // one round key from the previous one
  function automatic block_t next_round_key(input block_t k, input byte_t rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t  = sub_word({w3[23:0], w3[31:24]}) ^ {rc, 24'h0};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    next_round_key = {w0, w1, w2, w3};
  endfunction

endpackage

[rtl/aes128_key_sched.sv]
`timescale 1ns / 1ps
module aes128_key_sched (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  aes128_pkg::block_t            key,
  output aes128_pkg::block_t            round_keys [aes128_pkg::NumRnd+1]
);
  import aes128_pkg::*;

  logic [RkIdxW-1:0] step;
  logic              busy;

  // one round key per cycle while busy; a new key write restarts the schedule
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      if (step == RkIdxW'(NumRnd - 1)) begin
        busy <= 1'b0;
      end
      step <= step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      round_keys[0] <= key;
    end
    for (int r = 1; r <= NumRnd; r++) begin
      if (busy && !start && step == RkIdxW'(r - 1)) begin
        round_keys[r] <= next_round_key(round_keys[r-1], RCON[r-1]);
      end
    end
  end
endmodule

[rtl/aes128_round.sv]
`timescale 1ns / 1ps
module aes128_round (
  input  logic               clk,
  input  logic               en,
  input  logic               last,
  input  aes128_pkg::block_t state_in,
  input  aes128_pkg::block_t round_key,
  output aes128_pkg::block_t state_out
);
  import aes128_pkg::*;

  block_t ss;

  assign ss = sub_shift(state_in);

  always_ff @(posedge clk) begin
    if (en) begin
      state_out <= (last ? ss : mix_columns(ss)) ^ round_key;
    end
  end
endmodule

[rtl/aes128_block_encrypt_core.sv]
`timescale 1ns / 1ps
// AES-128 encryption core, one 128-bit block per clock unless a valid result is
// held by out_stall. The key is written as two 64-bit halves (index 0 = key
// bytes 0..7, index 1 = bytes 8..15); every write restarts the key schedule,
// and it must finish before blocks are sent in. Keys must be applied only
// while the core is idle; the core itself does not enforce this.
// Each block passes an input AddRoundKey stage and ten round stages, one
// round per register stage, and throughput is one block per cycle while the
// pipeline advances. The whole pipeline advances together: when the output
// is stalled and holds a valid result, every stage holds, and the input is
// stalled exactly then. Byte 0 is in the top bits of each upper half.
module aes128_block_encrypt_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] plain_upper,
  input  logic [63:0] plain_lower,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] cipher_upper,
  output logic [63:0] cipher_lower
);
  import aes128_pkg::*;

  logic [HalfW-1:0] key_upper;
  logic [HalfW-1:0] key_lower;
  block_t           key_next;
  block_t           round_keys [NumRnd+1];

  // stage 0 is the initial AddRoundKey, stages 1..10 are the rounds
  block_t           st    [NumRnd+1];
  logic [NumRnd:0]  vld;
  logic             adv;

  always_comb begin
    key_next = {key_upper, key_lower};
    if (cfg_we && cfg_index == CfgKeyUpper) begin
      key_next[127:64] = cfg_data;
    end
    if (cfg_we && cfg_index == CfgKeyLower) begin
      key_next[63:0] = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_upper <= '0;
      key_lower <= '0;
    end else begin
      key_upper <= key_next[127:64];
      key_lower <= key_next[63:0];
    end
  end

  aes128_key_sched u_ks (
    .clk        (clk),
    .rst        (rst),
    .start      (cfg_we),
    .key        (key_next),
    .round_keys (round_keys)
  );

  // pipeline moves as one; a free output slot lets everything shift
  assign adv      = ~out_stall | ~vld[NumRnd];
  assign in_stall = ~adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NumRnd-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0] <= {plain_upper, plain_lower} ^ round_keys[0];
    end
  end

  for (genvar r = 1; r <= NumRnd; r++) begin : g_rnd
    aes128_round u_round (
      .clk       (clk),
      .en        (adv),
      .last      (r == NumRnd),
      .state_in  (st[r-1]),
      .round_key (round_keys[r]),
      .state_out (st[r])
    );
  end

  assign out_valid    = vld[NumRnd];
  assign cipher_upper = st[NumRnd][127:64];
  assign cipher_lower = st[NumRnd][63:0];
endmodule

[rtl/aes128_checker.sv]
`timescale 1ns / 1ps
module aes128_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] cipher_upper,
  input logic [63:0] cipher_lower
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(cipher_upper) && $stable(cipher_lower))
    else $error("stalled result changed");

  a_back_press: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while output blocked");

  a_no_stall_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind aes128_block_encrypt_core aes128_checker u_chk (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .cipher_upper (cipher_upper),
  .cipher_lower (cipher_lower)
);

[bench/aes128_block_encrypt_core_tb.sv]
`timescale 1ns / 1ps
module aes128_block_encrypt_core_tb;
  import aes128_pkg::*;

  localparam int CycleLimit = 200000;
  // margins for the key schedule to settle after a write and for the pipeline to drain
  localparam int KeySettle  = 16;
  localparam int DrainWait  = 16;

  typedef struct packed {
    logic [63:0] upper;
    logic [63:0] lower;
  } blk_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = CfgKeyUpper;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] plain_upper = '0;
  logic [63:0] plain_lower = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] cipher_upper;
  logic [63:0] cipher_lower;

  aes128_block_encrypt_core dut (.*);

  always #5 clk = ~clk;

  // local copy of the key and its schedule
  byte_t       sub_tab [256];
  logic [31:0] rk_words [44];
  logic [63:0] key_hi = '0;
  logic [63:0] key_lo = '0;

  blk_t plain_q [$];   // blocks waiting to be sent
  blk_t cipher_q [$];  // ciphertexts due, oldest first

  int snd_idle = 0;
  int rcv_idle = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_keys = 0;
  int n_err = 0;
  int cycles = 0;

  function automatic byte_t gf_mul(byte_t a, byte_t b);
    byte_t p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  // S-box built from the field inverse plus the affine map
  function automatic void build_sub_tab();
    byte_t inv, s;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h00;
      for (int y = 1; y < 256; y++)
        if (gf_mul(byte_t'(x), byte_t'(y)) == 8'h01) inv = byte_t'(y);
      s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      sub_tab[x] = s;
    end
  endfunction

  function automatic void expand_schedule();
    logic [31:0] t;
    byte_t rc;
    rk_words[0] = key_hi[63:32];
    rk_words[1] = key_hi[31:0];
    rk_words[2] = key_lo[63:32];
    rk_words[3] = key_lo[31:0];
    rc = 8'h01;
    for (int i = 4; i < 44; i++) begin
      t = rk_words[i-1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {sub_tab[t[31:24]], sub_tab[t[23:16]], sub_tab[t[15:8]], sub_tab[t[7:0]]}
            ^ {rc, 24'h0};
        rc = gf_mul(rc, 8'h02);
      end
      rk_words[i] = rk_words[i-4] ^ t;
    end
  endfunction

  function automatic blk_t encrypt_block(blk_t pt);
    byte_t st [16];
    byte_t tmp [16];
    byte_t a0, a1, a2, a3;
    blk_t  ct;
    for (int i = 0; i < 8; i++) begin
      st[i]   = pt.upper[63-8*i -: 8];
      st[8+i] = pt.lower[63-8*i -: 8];
    end
    for (int rnd = 0; rnd <= 10; rnd++) begin
      if (rnd > 0) begin
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++)
            tmp[4*c+r] = sub_tab[st[4*((c+r)%4)+r]];
        st = tmp;
        if (rnd < 10) begin
          for (int c = 0; c < 4; c++) begin
            a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
            st[4*c]   = gf_mul(a0, 8'h02) ^ gf_mul(a1, 8'h03) ^ a2 ^ a3;
            st[4*c+1] = a0 ^ gf_mul(a1, 8'h02) ^ gf_mul(a2, 8'h03) ^ a3;
            st[4*c+2] = a0 ^ a1 ^ gf_mul(a2, 8'h02) ^ gf_mul(a3, 8'h03);
            st[4*c+3] = gf_mul(a0, 8'h03) ^ a1 ^ a2 ^ gf_mul(a3, 8'h02);
          end
        end
      end
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          st[4*c+r] ^= rk_words[4*rnd+c][31-8*r -: 8];
    end
    for (int i = 0; i < 8; i++) begin
      ct.upper[63-8*i -: 8] = st[i];
      ct.lower[63-8*i -: 8] = st[8+i];
    end
    return ct;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Driver: a payload stays put until its transfer; one NBA per signal per edge.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        cipher_q.push_back(encrypt_block('{upper: plain_upper, lower: plain_lower}));
        n_sent++;
      end
      if (!(in_valid && in_stall)) begin
        if (plain_q.size() > 0 && $urandom_range(99) >= snd_idle) begin
          blk_t b;
          b = plain_q.pop_front();
          plain_upper <= b.upper;
          plain_lower <= b.lower;
          in_valid    <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure, compare each transfer with the oldest due result.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still due", cycles, cipher_q.size());
      $display("aes128_block_encrypt_core_tb failed");
      $finish;
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (cipher_q.size() == 0) begin
          n_err++;
          if (n_err <= 10)
            $display("unexpected result %h %h", cipher_upper, cipher_lower);
        end else begin
          blk_t e;
          e = cipher_q.pop_front();
          n_checked++;
          if (cipher_upper !== e.upper) begin
            n_err++;
            if (n_err <= 10)
              $display("cipher_upper mismatch: expected %h got %h", e.upper, cipher_upper);
          end
          if (cipher_lower !== e.lower) begin
            n_err++;
            if (n_err <= 10)
              $display("cipher_lower mismatch: expected %h got %h", e.lower, cipher_lower);
          end
        end
      end
      out_stall <= ($urandom_range(99) < rcv_idle);
    end
  end

  task automatic wait_idle();
    while (plain_q.size() != 0 || in_valid || cipher_q.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  // Key registers only change with the core drained; the schedule then settles.
  task automatic write_key(bit wr_hi, bit wr_lo, logic [63:0] hi, logic [63:0] lo);
    wait_idle();
    if (wr_hi) begin
      cfg_we <= 1'b1; cfg_index <= CfgKeyUpper; cfg_data <= hi;
      key_hi = hi;
      @(posedge clk);
    end
    if (wr_lo) begin
      cfg_we <= 1'b1; cfg_index <= CfgKeyLower; cfg_data <= lo;
      key_lo = lo;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    expand_schedule();
    n_keys++;
    repeat (KeySettle) @(posedge clk);
  endtask

  task automatic push_block(logic [63:0] u, logic [63:0] l);
    plain_q.push_back('{upper: u, lower: l});
  endtask

  initial begin
    blk_t chk;
    build_sub_tab();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // sanity of the local predictor against the standard example vector
    key_hi = 64'h0001020304050607;
    key_lo = 64'h08090a0b0c0d0e0f;
    expand_schedule();
    chk = encrypt_block('{upper: 64'h0011223344556677, lower: 64'h8899aabbccddeeff});
    if (chk !== {64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a}) begin
      n_err++;
      $display("predictor self-check wrong: %h", chk);
    end

    // directed: extreme keys and edge plaintexts
    snd_idle = 15; rcv_idle = 58;
    write_key(1, 1, '0, '0);
    push_block('0, '0);
    push_block('1, '1);
    push_block(64'h8000000000000000, 64'h0000000000000001);
    write_key(1, 1, '1, '1);
    push_block('0, '0);
    push_block('1, '1);
    push_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
    write_key(1, 1, 64'h0001020304050607, 64'h08090a0b0c0d0e0f);
    push_block(64'h0011223344556677, 64'h8899aabbccddeeff);
    push_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    // partial updates: the other half keeps its value
    write_key(1, 0, 64'hffffffffffffffff, '0);
    push_block(64'h0011223344556677, 64'h8899aabbccddeeff);
    write_key(0, 1, '0, 64'h8000000000000001);
    push_block('0, '1);

    // random: three idling regimes, four keys each, some partial updates
    for (int ph = 0; ph < 3; ph++) begin
      snd_idle = (ph == 0) ? 15 : (ph == 1) ? 58 : 0;
      rcv_idle = (ph == 0) ? 58 : (ph == 1) ? 15 : 0;
      for (int k = 0; k < 4; k++) begin
        case ($urandom_range(3))
          0:       write_key(1, 0, rand64(), key_lo);
          1:       write_key(0, 1, key_hi, rand64());
          default: write_key(1, 1, rand64(), rand64());
        endcase
        for (int n = 0; n < 80; n++) begin
          if ($urandom_range(9) == 0)
            push_block(64'h1 << $urandom_range(63), 64'h1 << $urandom_range(63));
          else
            push_block(rand64(), rand64());
        end
      end
    end

    wait_idle();
    $display("%0d blocks encrypted under %0d key settings, %0d results checked",
             n_sent, n_keys, n_checked);
    $display("covered zero/all-ones/standard keys, partial key updates and three stall mixes");
    if (n_err == 0 && cipher_q.size() == 0) begin
      $display("aes128_block_encrypt_core_tb passed");
    end else begin
      $display("%0d mismatches", n_err);
      $display("aes128_block_encrypt_core_tb failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/aes128_pkg.sv
rtl/aes128_key_sched.sv
rtl/aes128_round.sv
rtl/aes128_block_encrypt_core.sv
rtl/aes128_checker.sv
bench/aes128_block_encrypt_core_tb.sv
